>>> sv/sktl_pkg.sv
package sktl_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int POS_W   = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRT_RDS,
		ST_SRT_CAPS,
		ST_SRT_RDI,
		ST_SRT_CMPI,
		ST_SRT_WRA,
		ST_SRT_WRB,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_DONE
	} state_t;

	typedef struct packed {
		logic ld;
		logic ld_last;
		logic q_start;
		logic rd_s;
		logic cap_s;
		logic rd_i;
		logic cmp_i;
		logic wr_a;
		logic wr_b;
		logic q_rd;
		logic q_cmp;
		logic q_out;
	} cmd_t;

	typedef struct packed {
		logic sort_more;
		logic scan_more;
		logic q_live;
		logic q_hit;
		logic out_free;
	} status_t;

endpackage

>>> sv/sktl_ctrl.sv
module sktl_ctrl
	import sktl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    kind,
	input  logic    last_load,
	input  status_t sts,
	output logic    in_ready,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (kind) begin
						state_d = ST_Q_RD;
					end else if (last_load) begin
						state_d = ST_SRT_RDS;
					end
				end
			end
			ST_SRT_RDS:  state_d = sts.sort_more ? ST_SRT_CAPS : ST_IDLE;
			ST_SRT_CAPS: state_d = ST_SRT_RDI;
			ST_SRT_RDI:  state_d = ST_SRT_CMPI;
			ST_SRT_CMPI: state_d = sts.scan_more ? ST_SRT_RDI : ST_SRT_WRA;
			ST_SRT_WRA:  state_d = ST_SRT_WRB;
			ST_SRT_WRB:  state_d = ST_SRT_RDS;
			ST_Q_RD:     state_d = sts.q_live ? ST_Q_CMP : ST_Q_DONE;
			ST_Q_CMP:    state_d = sts.q_hit ? ST_Q_DONE : ST_Q_RD;
			ST_Q_DONE:   state_d = sts.out_free ? ST_IDLE : ST_Q_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ld      = take && !kind;
				cmd.ld_last = take && !kind && last_load;
				cmd.q_start = take && kind;
			end
			ST_SRT_RDS:  cmd.rd_s  = sts.sort_more;
			ST_SRT_CAPS: cmd.cap_s = 1'b1;
			ST_SRT_RDI:  cmd.rd_i  = 1'b1;
			ST_SRT_CMPI: cmd.cmp_i = 1'b1;
			ST_SRT_WRA:  cmd.wr_a  = 1'b1;
			ST_SRT_WRB:  cmd.wr_b  = 1'b1;
			ST_Q_RD:     cmd.q_rd  = sts.q_live;
			ST_Q_CMP:    cmd.q_cmp = 1'b1;
			ST_Q_DONE:   cmd.q_out = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

>>> sv/sktl_datapath.sv
module sktl_datapath
	import sktl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic signed [31:0] key,
	input  logic              out_ready,
	output status_t           sts,
	output logic              out_valid,
	output logic              found,
	output logic [4:0]        position,
	output logic              overflowed
);

	logic [KEY_W-1:0] mem [ENTRIES];
	logic [KEY_W-1:0] rdata_q;

	logic [CNT_W-1:0] count_q;
	logic             phase_q;
	logic             ovf_q;
	logic             out_valid_q;

	logic [IDX_W-1:0] s_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] mi_q;
	logic [KEY_W-1:0] min_q;
	logic [KEY_W-1:0] sval_q;

	logic [KEY_W-1:0] target_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hx_q;
	logic [IDX_W-1:0] mid_q;
	logic             hit_q;
	logic [IDX_W-1:0] pos_q;
	logic             found_q;
	logic [POS_W-1:0] position_q;
	logic             ovf_out_q;

	logic [CNT_W-1:0] base;
	logic             room;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [KEY_W-1:0] wdata;

	assign base    = phase_q ? '0 : count_q;
	assign room    = base < CNT_W'(ENTRIES);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CNT_W + 1)'(1);
	assign mid     = mid_sum[IDX_W:1];

	assign sts.sort_more = (CNT_W'(s_q) + CNT_W'(1)) < count_q;
	assign sts.scan_more = (CNT_W'(i_q) + CNT_W'(1)) < count_q;
	assign sts.q_live    = lo_q < hx_q;
	assign sts.q_hit     = rdata_q == target_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		raddr = mid;
		if (cmd.rd_s) begin
			raddr = s_q;
		end else if (cmd.rd_i) begin
			raddr = i_q;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = s_q;
		wdata = min_q;
		if (cmd.ld) begin
			we    = room;
			waddr = base[IDX_W-1:0];
			wdata = key;
		end else if (cmd.wr_a) begin
			we    = 1'b1;
			waddr = mi_q;
			wdata = sval_q;
		end else if (cmd.wr_b) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			phase_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld) begin
				phase_q <= 1'b0;
				count_q <= room ? base + CNT_W'(1) : base;
				ovf_q   <= (ovf_q && !phase_q) || !room;
			end else if (cmd.q_start) begin
				phase_q <= 1'b1;
			end
			if (cmd.q_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_last) begin
			s_q <= '0;
		end else if (cmd.wr_b) begin
			s_q <= s_q + IDX_W'(1);
		end
		if (cmd.cap_s) begin
			min_q  <= rdata_q;
			sval_q <= rdata_q;
			mi_q   <= s_q;
			i_q    <= s_q + IDX_W'(1);
		end else if (cmd.cmp_i) begin
			if ($signed(rdata_q) < $signed(min_q)) begin
				min_q <= rdata_q;
				mi_q  <= i_q;
			end
			i_q <= i_q + IDX_W'(1);
		end
		if (cmd.q_start) begin
			target_q <= key;
			lo_q     <= '0;
			hx_q     <= count_q;
			hit_q    <= 1'b0;
			pos_q    <= '0;
		end else if (cmd.q_rd) begin
			mid_q <= mid;
		end else if (cmd.q_cmp) begin
			if (rdata_q == target_q) begin
				hit_q <= 1'b1;
				pos_q <= mid_q;
			end else if ($signed(rdata_q) > $signed(target_q)) begin
				hx_q <= CNT_W'(mid_q);
			end else begin
				lo_q <= CNT_W'(mid_q) + CNT_W'(1);
			end
		end
		if (cmd.q_out) begin
			found_q    <= hit_q;
			position_q <= POS_W'(pos_q);
			ovf_out_q  <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign position   = position_q;
	assign overflowed = ovf_out_q;

endmodule

>>> sv/sorted_key_table_lookup_unit.sv
// sorted key table with lookup
// input channel (in_valid/in_ready): kind 0 loads key into the table, kind 1
// queries key; last_load on a load makes the block sort the table ascending.
// output channel (out_valid/out_ready): one item per query with found,
// position and overflowed; loads give no output item.
// a last load is followed by a selection sort over the key memory (one read
// port, one write port): per start slot a read, a capture, a read and compare
// per remaining key, then two writes for the swap; in_ready is low meanwhile.
// a query makes each probe of the binary search as a memory read, then a
// compare, and ends by placing its result in the output register.
// the result sits in an output register; loads are still taken while it
// waits, but a following query holds at its end until out_ready frees it.
// reset empties the table, clears the overflow flag and out_valid; key
// memory contents are not cleared and slots are read only once written.
module sorted_key_table_lookup_unit
	import sktl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [31:0] key,
	input  logic               last_load,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [4:0]         position,
	output logic               overflowed
);

	cmd_t    cmd;
	status_t sts;

	sktl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.last_load (last_load),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	sktl_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.key        (key),
		.out_ready  (out_ready),
		.sts        (sts),
		.out_valid  (out_valid),
		.found      (found),
		.position   (position),
		.overflowed (overflowed)
	);

endmodule

>>> test/tb_top.sv
module tb_top
	import sktl_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam bit KIND_LOAD   = 1'b0;
	localparam bit KIND_QUERY  = 1'b1;
	localparam int ITEM_TARGET = 1800;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 200;

	typedef struct {
		bit               found;
		bit [POS_W-1:0]   position;
		bit               overflowed;
	} lookup_result_t;

	class lookup_scoreboard;
		logic signed [KEY_W-1:0] slots [ENTRIES];
		int unsigned             key_count;
		bit                      query_phase;
		bit                      dropped_load;
		lookup_result_t          expected_q[$];
		int                      errors;

		function new();
			key_count    = 0;
			query_phase  = 1'b0;
			dropped_load = 1'b0;
			errors       = 0;
		endfunction

		function void note_item(bit item_kind, logic signed [KEY_W-1:0] item_key, bit last);
			lookup_result_t          res;
			logic signed [KEY_W-1:0] tmp;
			int                      lo, hi, mid, mi;

			if (item_kind == KIND_LOAD) begin
				if (query_phase) begin
					query_phase  = 1'b0;
					key_count    = 0;
					dropped_load = 1'b0;
				end
				if (key_count < ENTRIES) begin
					slots[key_count] = item_key;
					key_count++;
				end else begin
					dropped_load = 1'b1;
				end
				if (last) begin
					// selection sort, first smallest swapped into place
					for (int s = 0; s + 1 < key_count; s++) begin
						mi = s;
						for (int i = s + 1; i < key_count; i++)
							if (slots[i] < slots[mi])
								mi = i;
						tmp       = slots[mi];
						slots[mi] = slots[s];
						slots[s]  = tmp;
					end
				end
			end else begin
				query_phase    = 1'b1;
				res.found      = 1'b0;
				res.position   = '0;
				res.overflowed = dropped_load;
				lo = 0;
				hi = int'(key_count) - 1;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (slots[mid] == item_key) begin
						res.found    = 1'b1;
						res.position = mid[POS_W-1:0];
						break;
					end
					if (slots[mid] > item_key)
						hi = mid - 1;
					else
						lo = mid + 1;
				end
				expected_q.push_back(res);
			end
		endfunction

		function void check_result(bit f, bit [POS_W-1:0] p, bit o);
			lookup_result_t exp_res;

			if (expected_q.size() == 0) begin
				$error("unexpected result item: found %0d position %0d overflowed %0d", f, p, o);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (f !== exp_res.found) begin
				$error("found: expected %0d, actual %0d", exp_res.found, f);
				errors++;
			end
			if (p !== exp_res.position) begin
				$error("position: expected %0d, actual %0d", exp_res.position, p);
				errors++;
			end
			if (o !== exp_res.overflowed) begin
				$error("overflowed: expected %0d, actual %0d", exp_res.overflowed, o);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    kind;
	logic signed [KEY_W-1:0] key;
	logic                    last_load;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic [POS_W-1:0]        position;
	logic                    overflowed;

	lookup_scoreboard sb;
	int               items_sent;
	int               results_seen;
	int               stall_cycles;

	sorted_key_table_lookup_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.key        (key),
		.last_load  (last_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.position   (position),
		.overflowed (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// entered and left at a falling edge
	task automatic send_item(bit item_kind, logic signed [KEY_W-1:0] item_key, bit last);
		while (!(items_sent >= 700 && items_sent < 1000) &&
				$urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= item_kind;
		key       <= item_key;
		last_load <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] rand_key();
		logic signed [KEY_W-1:0] v;
		int unsigned             pick;

		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			v = $urandom;
		end else if (pick < 80) begin
			v = $urandom_range(0, 31);
			v = v - 16;
		end else if (pick < 90) begin
			v = 32'sh7fffffff;
			v = v - $urandom_range(0, 3);
		end else begin
			v = 32'sh80000000;
			v = v + $urandom_range(0, 3);
		end
		return v;
	endfunction

	// monitor for both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_result(found, position, overflowed);
				results_seen++;
			end
			if (in_valid && in_ready)
				sb.note_item(kind, key, last_load);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver
	initial begin
		bit hold_done;

		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 150) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (results_seen >= 300 && results_seen < 450) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 16);
			end
		end
	end

	initial begin
		logic signed [KEY_W-1:0] set_keys[$];
		logic signed [KEY_W-1:0] qk;
		int                      n_loads, n_queries, pick;
		bit                      do_sort, last;

		sb           = new();
		items_sent   = 0;
		results_seen = 0;
		stall_cycles = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_LOAD;
		key          = '0;
		last_load    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table
		send_item(KIND_QUERY, 32'sd5, 1'b0);
		// extremes, zero, minus one, repeated key, then sort
		send_item(KIND_LOAD, 32'sh7fffffff, 1'b0);
		send_item(KIND_LOAD, 32'sh80000000, 1'b0);
		send_item(KIND_LOAD, 32'sd0, 1'b0);
		send_item(KIND_LOAD, -32'sd1, 1'b0);
		send_item(KIND_LOAD, 32'sd7, 1'b0);
		send_item(KIND_LOAD, 32'sd7, 1'b1);
		send_item(KIND_QUERY, 32'sh80000000, 1'b0);
		send_item(KIND_QUERY, 32'sh7fffffff, 1'b1);
		send_item(KIND_QUERY, 32'sd0, 1'b0);
		send_item(KIND_QUERY, -32'sd1, 1'b0);
		send_item(KIND_QUERY, 32'sd7, 1'b0);
		send_item(KIND_QUERY, 32'sd3, 1'b0);
		// new set searched before any sort
		send_item(KIND_LOAD, 32'sd9, 1'b0);
		send_item(KIND_LOAD, -32'sd4, 1'b0);
		send_item(KIND_LOAD, 32'sd20, 1'b0);
		send_item(KIND_QUERY, -32'sd4, 1'b0);
		send_item(KIND_QUERY, 32'sd20, 1'b0);
		send_item(KIND_QUERY, 32'sd9, 1'b0);
		// single entry
		send_item(KIND_LOAD, 32'sd5, 1'b1);
		send_item(KIND_QUERY, 32'sd5, 1'b0);
		send_item(KIND_QUERY, 32'sd6, 1'b0);

		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				n_loads = $urandom_range(1, 8);
			else if (pick < 88)
				n_loads = $urandom_range(9, 32);
			else
				n_loads = $urandom_range(33, 38);
			do_sort = ($urandom_range(0, 99) < 90);
			set_keys.delete();
			for (int i = 0; i < n_loads; i++) begin
				qk = rand_key();
				set_keys.push_back(qk);
				last = (do_sort && i == n_loads - 1) || ($urandom_range(0, 99) < 3);
				send_item(KIND_LOAD, qk, last);
			end
			n_queries = $urandom_range(1, 12);
			for (int i = 0; i < n_queries; i++) begin
				pick = $urandom_range(0, 99);
				qk   = set_keys[$urandom_range(0, set_keys.size() - 1)];
				if (pick >= 65 && pick < 75)
					qk = ($urandom_range(0, 1) != 0) ? qk + 1 : qk - 1;
				else if (pick >= 75)
					qk = rand_key();
				send_item(KIND_QUERY, qk, 1'($urandom_range(0, 1)));
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
